/* src/pdgs_pkg.sv */
// ----------------------------------------------------------------------------
// pdgs_pkg
// Shared types, constants and lookup tables of the power domain gating
// sequencer.
// ----------------------------------------------------------------------------
package pdgs_pkg;

    // Geometry
    localparam int NUM_DOMAINS_DEF = 5;
    localparam int HW_MASK_W       = 5;
    localparam int DOM_W           = 3;
    localparam int STATUS_W        = 16;
    localparam int DELAY_W         = 9;
    localparam int IVAL_W          = 6;
    localparam int POLL_W          = 14;
    localparam int CTRL_W          = 5;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 14;
    localparam int OP_W            = 2;
    localparam int CHAIN_STEPS     = 4;

    // Item kinds carried in s_tuser
    localparam logic [OP_W-1:0] OP_TICK = 2'd0;
    localparam logic [OP_W-1:0] OP_ON   = 2'd1;
    localparam logic [OP_W-1:0] OP_OFF  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HW_MASK     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLEEP_DLY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ISO_DLY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HW_ON_DLY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HW_OFF_DLY  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_ON_IV  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_OFF_IV = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_POLL_LIMIT  = 3'd7;

    // Configuration reset values
    localparam logic [HW_MASK_W-1:0] HW_MASK_RST     = 5'd24;
    localparam logic [DELAY_W-1:0]   SLEEP_DLY_RST   = 9'd25;
    localparam logic [DELAY_W-1:0]   ISO_DLY_RST     = 9'd15;
    localparam logic [DELAY_W-1:0]   HW_ON_DLY_RST   = 9'd310;
    localparam logic [DELAY_W-1:0]   HW_OFF_DLY_RST  = 9'd30;
    localparam logic [IVAL_W-1:0]    POLL_ON_IV_RST  = 6'd6;
    localparam logic [IVAL_W-1:0]    POLL_OFF_IV_RST = 6'd5;
    localparam logic [POLL_W-1:0]    POLL_LIMIT_RST  = 14'd10000;

    // Control bits of a domain
    localparam logic [CTRL_W-1:0] CB_AUTOON = 5'b00001;
    localparam logic [CTRL_W-1:0] CB_ISO    = 5'b00010;
    localparam logic [CTRL_W-1:0] CB_SLEEP1 = 5'b00100;
    localparam logic [CTRL_W-1:0] CB_SLEEP2 = 5'b01000;
    localparam logic [CTRL_W-1:0] CB_HWMODE = 5'b10000;

    typedef enum logic [8:0] {
        PH_IDLE      = 9'b000000001,
        PH_ON_SLEEP1 = 9'b000000010,
        PH_ON_SLEEP2 = 9'b000000100,
        PH_ON_ISO    = 9'b000001000,
        PH_OFF_ISO   = 9'b000010000,
        PH_OFF_SLEEP = 9'b000100000,
        PH_HW_WAIT   = 9'b001000000,
        PH_POLL_SW   = 9'b010000000,
        PH_POLL_HW   = 9'b100000000
    } phase_t;

    // Status bit watched for a software-managed domain
    function automatic logic [3:0] sw_stat_bit(input logic [DOM_W-1:0] d);
        logic [3:0] b;
        case (d)
            3'd0:    b = 4'd1;
            3'd2:    b = 4'd3;
            3'd3:    b = 4'd4;
            3'd4:    b = 4'd5;
            default: b = 4'd0;
        endcase
        return b;
    endfunction

    // Status bit watched for a hardware-managed domain
    function automatic logic [3:0] hw_stat_bit(input logic [DOM_W-1:0] d);
        logic [3:0] b;
        case (d)
            3'd0:    b = 4'd9;
            3'd3:    b = 4'd12;
            3'd4:    b = 4'd15;
            default: b = 4'd0;
        endcase
        return b;
    endfunction

    // Only the first five domains can be hardware-managed
    function automatic logic is_hw(input logic [DOM_W-1:0] d,
                                   input logic [HW_MASK_W-1:0] mask);
        logic [7:0] ext;
        ext = {3'b000, mask};
        return ext[d];
    endfunction

endpackage

/* src/power_domain_gating_sequencer_core.sv */
// ----------------------------------------------------------------------------
// power_domain_gating_sequencer_core
// Sequences power gating of up to NUM_DOMAINS domains from a stream of
// microsecond ticks and power-on / power-off requests.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream: one transfer per item. s_tuser carries the kind (tick,
//   power-on, power-off); s_tdata carries the domain and the sampled power
//   status word. m_* stream: one result transfer per input transfer, in order,
//   reporting the active domain, its control bits and the busy / done /
//   timeout / reject flags.
//   cfg_* channel: register writes by index, always ready; write only while
//   no sequence is running and no item is in flight.
// Timing:
//   An item is registered at the input, processed by the sequencer logic and
//   lands in the result register. One item per cycle sustained while m_tready
//   stays high; the sequencer state register is updated once per item.
// Stall:
//   If m_tready is low the result register holds; the input register still
//   takes one more item, then s_tready drops until the result drains.
// Reset:
//   aresetn (synchronous, active low) empties both stages, returns the
//   sequencer to idle, clears all domain control bits and loads the
//   register defaults.
// ----------------------------------------------------------------------------
module power_domain_gating_sequencer_core #(
    parameter int NUM_DOMAINS = pdgs_pkg::NUM_DOMAINS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [2:0] domain, [18:3] status_word, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] op
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [2:0] active_domain, [7:3] ctrl_value,
                                   // [8] busy_res, [9] done_res,
                                   // [10] timed_out, [11] rejected, rest zero
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [13:0] cfg_data
);

    localparam int IDX_W = (NUM_DOMAINS > 1) ? $clog2(NUM_DOMAINS) : 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [pdgs_pkg::HW_MASK_W-1:0] hw_mask_reg;
    logic [pdgs_pkg::DELAY_W-1:0]   sleep_dly_reg;
    logic [pdgs_pkg::DELAY_W-1:0]   iso_dly_reg;
    logic [pdgs_pkg::DELAY_W-1:0]   hw_on_dly_reg;
    logic [pdgs_pkg::DELAY_W-1:0]   hw_off_dly_reg;
    logic [pdgs_pkg::IVAL_W-1:0]    poll_on_iv_reg;
    logic [pdgs_pkg::IVAL_W-1:0]    poll_off_iv_reg;
    logic [pdgs_pkg::POLL_W-1:0]    poll_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hw_mask_reg     <= pdgs_pkg::HW_MASK_RST;
            sleep_dly_reg   <= pdgs_pkg::SLEEP_DLY_RST;
            iso_dly_reg     <= pdgs_pkg::ISO_DLY_RST;
            hw_on_dly_reg   <= pdgs_pkg::HW_ON_DLY_RST;
            hw_off_dly_reg  <= pdgs_pkg::HW_OFF_DLY_RST;
            poll_on_iv_reg  <= pdgs_pkg::POLL_ON_IV_RST;
            poll_off_iv_reg <= pdgs_pkg::POLL_OFF_IV_RST;
            poll_limit_reg  <= pdgs_pkg::POLL_LIMIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                pdgs_pkg::REG_HW_MASK:     hw_mask_reg     <= cfg_data[4:0];
                pdgs_pkg::REG_SLEEP_DLY:   sleep_dly_reg   <= cfg_data[8:0];
                pdgs_pkg::REG_ISO_DLY:     iso_dly_reg     <= cfg_data[8:0];
                pdgs_pkg::REG_HW_ON_DLY:   hw_on_dly_reg   <= cfg_data[8:0];
                pdgs_pkg::REG_HW_OFF_DLY:  hw_off_dly_reg  <= cfg_data[8:0];
                pdgs_pkg::REG_POLL_ON_IV:  poll_on_iv_reg  <= cfg_data[5:0];
                pdgs_pkg::REG_POLL_OFF_IV: poll_off_iv_reg <= cfg_data[5:0];
                pdgs_pkg::REG_POLL_LIMIT:  poll_limit_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic                            in_valid_reg;
    logic [pdgs_pkg::OP_W-1:0]       in_op_reg;
    logic [pdgs_pkg::DOM_W-1:0]      in_dom_reg;
    logic [pdgs_pkg::STATUS_W-1:0]   in_stat_reg;
    logic                            out_valid_reg;
    logic                            advance;

    // an item moves into the result register when that slot is free or drains
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= s_tuser;
            in_dom_reg  <= s_tdata[2:0];
            in_stat_reg <= s_tdata[18:3];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    pdgs_pkg::phase_t              phase_reg, phase_next;
    logic [pdgs_pkg::DELAY_W-1:0]  delay_reg, delay_next;
    logic [pdgs_pkg::POLL_W-1:0]   poll_reg, poll_next;
    logic [pdgs_pkg::DOM_W-1:0]    cur_reg, cur_next;
    logic                          pon_reg, pon_next;
    logic [pdgs_pkg::CTRL_W-1:0]   ctrl_reg [NUM_DOMAINS];
    logic [pdgs_pkg::CTRL_W-1:0]   ctrl_next;
    logic                          ctrl_we;

    logic       is_req, dom_ok, take, tick_busy;
    logic       done_r, tmo_r, rej_r;
    logic [3:0] sbit;
    logic       on_bit;
    logic [pdgs_pkg::IVAL_W-1:0] iv;

    assign is_req    = (in_op_reg == pdgs_pkg::OP_ON) || (in_op_reg == pdgs_pkg::OP_OFF);
    assign dom_ok    = ({2'b00, in_dom_reg} < 5'(NUM_DOMAINS));
    assign take      = is_req && (phase_reg == pdgs_pkg::PH_IDLE) && dom_ok;
    assign tick_busy = (in_op_reg == pdgs_pkg::OP_TICK) && (phase_reg != pdgs_pkg::PH_IDLE);
    assign ctrl_we   = advance && (take || tick_busy);

    always_comb begin
        phase_next = phase_reg;
        delay_next = delay_reg;
        poll_next  = poll_reg;
        cur_next   = cur_reg;
        pon_next   = pon_reg;
        done_r     = 1'b0;
        tmo_r      = 1'b0;
        rej_r      = 1'b0;
        sbit       = 4'd0;
        on_bit     = 1'b0;
        iv         = '0;
        ctrl_next  = take ? ctrl_reg[IDX_W'(in_dom_reg)] : ctrl_reg[IDX_W'(cur_reg)];

        if (tick_busy) begin
            if (delay_next != '0) begin
                delay_next = delay_next - 9'd1;
            end
        end else if (is_req && (phase_reg != pdgs_pkg::PH_IDLE)) begin
            rej_r = 1'b1;
        end else if (take) begin
            cur_next  = in_dom_reg;
            poll_next = '0;
            pon_next  = (in_op_reg == pdgs_pkg::OP_ON);
            if (in_op_reg == pdgs_pkg::OP_ON) begin
                if (in_stat_reg[pdgs_pkg::sw_stat_bit(in_dom_reg)]) begin
                    // already powered: finish right away
                    done_r = 1'b1;
                end else if (pdgs_pkg::is_hw(in_dom_reg, hw_mask_reg)) begin
                    ctrl_next  = ctrl_next | pdgs_pkg::CB_AUTOON | pdgs_pkg::CB_HWMODE;
                    delay_next = hw_on_dly_reg;
                    phase_next = pdgs_pkg::PH_HW_WAIT;
                end else begin
                    ctrl_next  = ctrl_next | pdgs_pkg::CB_SLEEP1;
                    delay_next = sleep_dly_reg;
                    phase_next = pdgs_pkg::PH_ON_SLEEP1;
                end
            end else if (pdgs_pkg::is_hw(in_dom_reg, hw_mask_reg)) begin
                ctrl_next  = ctrl_next & ~(pdgs_pkg::CB_AUTOON | pdgs_pkg::CB_HWMODE);
                delay_next = hw_off_dly_reg;
                phase_next = pdgs_pkg::PH_HW_WAIT;
            end else begin
                ctrl_next  = ctrl_next & ~pdgs_pkg::CB_ISO;
                delay_next = iso_dly_reg;
                phase_next = pdgs_pkg::PH_OFF_ISO;
            end
        end

        // Zero delays chain steps within one item. At most three steps
        // follow a request; a poll always leaves a nonzero delay or idle.
        if (take || tick_busy) begin
            for (int k = 0; k < pdgs_pkg::CHAIN_STEPS; k++) begin
                if ((phase_next != pdgs_pkg::PH_IDLE) && (delay_next == '0)) begin
                    case (phase_next)
                        pdgs_pkg::PH_ON_SLEEP1: begin
                            ctrl_next  = ctrl_next | pdgs_pkg::CB_SLEEP1 | pdgs_pkg::CB_SLEEP2;
                            delay_next = sleep_dly_reg;
                            phase_next = pdgs_pkg::PH_ON_SLEEP2;
                        end
                        pdgs_pkg::PH_ON_SLEEP2: begin
                            ctrl_next  = ctrl_next | pdgs_pkg::CB_ISO;
                            delay_next = iso_dly_reg;
                            phase_next = pdgs_pkg::PH_ON_ISO;
                        end
                        pdgs_pkg::PH_OFF_ISO: begin
                            ctrl_next  = ctrl_next & ~(pdgs_pkg::CB_SLEEP1 | pdgs_pkg::CB_SLEEP2);
                            delay_next = iso_dly_reg;
                            phase_next = pdgs_pkg::PH_OFF_SLEEP;
                        end
                        pdgs_pkg::PH_ON_ISO, pdgs_pkg::PH_OFF_SLEEP,
                        pdgs_pkg::PH_HW_WAIT, pdgs_pkg::PH_POLL_SW,
                        pdgs_pkg::PH_POLL_HW: begin
                            if (phase_next == pdgs_pkg::PH_HW_WAIT) begin
                                phase_next = pdgs_pkg::PH_POLL_HW;
                            end else if (phase_next != pdgs_pkg::PH_POLL_HW) begin
                                phase_next = pdgs_pkg::PH_POLL_SW;
                            end
                            sbit   = (phase_next == pdgs_pkg::PH_POLL_HW) ?
                                     pdgs_pkg::hw_stat_bit(cur_next) :
                                     pdgs_pkg::sw_stat_bit(cur_next);
                            on_bit = in_stat_reg[sbit];
                            if (pon_next ? on_bit : !on_bit) begin
                                phase_next = pdgs_pkg::PH_IDLE;
                                done_r     = 1'b1;
                            end else if (poll_next >= poll_limit_reg) begin
                                phase_next = pdgs_pkg::PH_IDLE;
                                tmo_r      = 1'b1;
                            end else begin
                                poll_next  = poll_next + 14'd1;
                                iv         = pon_next ? poll_on_iv_reg : poll_off_iv_reg;
                                // an interval of zero behaves as one
                                delay_next = (iv == '0) ? 9'd1 : {3'b000, iv};
                            end
                        end
                        default: phase_next = pdgs_pkg::PH_IDLE;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= pdgs_pkg::PH_IDLE;
            delay_reg <= '0;
            poll_reg  <= '0;
            cur_reg   <= '0;
            pon_reg   <= 1'b0;
        end else if (advance) begin
            phase_reg <= phase_next;
            delay_reg <= delay_next;
            poll_reg  <= poll_next;
            cur_reg   <= cur_next;
            pon_reg   <= pon_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int d = 0; d < NUM_DOMAINS; d++) begin
                ctrl_reg[d] <= '0;
            end
        end else if (ctrl_we) begin
            ctrl_reg[IDX_W'(cur_next)] <= ctrl_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [pdgs_pkg::DOM_W-1:0]  out_dom_reg;
    logic [pdgs_pkg::CTRL_W-1:0] out_ctrl_reg;
    logic                        out_busy_reg, out_done_reg, out_tmo_reg, out_rej_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_dom_reg  <= cur_next;
            out_ctrl_reg <= ctrl_next;
            out_busy_reg <= (phase_next != pdgs_pkg::PH_IDLE);
            out_done_reg <= done_r;
            out_tmo_reg  <= tmo_r;
            out_rej_reg  <= rej_r;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_rej_reg, out_tmo_reg, out_done_reg, out_busy_reg,
                       out_ctrl_reg, out_dom_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a running sequence always waits on a nonzero delay
    a_busy_delay: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != pdgs_pkg::PH_IDLE) |-> (delay_reg != '0))
        else $error("sequencer parked on zero delay");

    a_cur_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({2'b00, cur_reg} < 5'(NUM_DOMAINS)))
        else $error("current domain out of range");

    a_reject_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_rej_reg) |-> (out_busy_reg && !out_done_reg && !out_tmo_reg))
        else $error("reject reported without running sequence");

    a_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_done_reg || out_tmo_reg)) |-> !out_busy_reg)
        else $error("sequence end reported while busy");

    a_one_end: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_done_reg && out_tmo_reg))
        else $error("done and timeout on one item");

    a_poll_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && tmo_r |=> (phase_reg == pdgs_pkg::PH_IDLE))
        else $error("timeout did not end the sequence");

endmodule
